[hdl/sphere_drag_cd_re_evaluator_core_macros.svh]
// Assertion helpers used by the evaluator core.
`ifndef SPHERE_DRAG_CD_RE_EVALUATOR_CORE_MACROS_SVH
`define SPHERE_DRAG_CD_RE_EVALUATOR_CORE_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define SDRE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define SDRE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[hdl/sdre_pkg.sv]
package sdre_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned EXP_STEPS       = 24;

  // Q24 constants
  localparam logic signed [31:0] K_082     = 32'sd13757317;
  localparam logic signed [31:0] K_LOGTERM = 32'sd252522;
  localparam logic signed [31:0] K_06305   = 32'sd10578035;
  localparam logic signed [31:0] K_045     = 32'sd7549747;
  localparam logic [21:0]        K_01315   = 22'd2206204;
  localparam logic [21:0]        K_01935   = 22'd3246391;
  localparam logic [22:0]        K_044     = 23'd7381975;

  typedef enum logic [2:0] {
    REGION_STOKES = 3'd0,
    REGION_LOW    = 3'd1,
    REGION_MID    = 3'd2,
    REGION_HIGH   = 3'd3,
    REGION_NEWTON = 3'd4
  } region_e;

  typedef struct packed {
    logic [31:0] x;
    region_e     region;
    logic [4:0]  lead;
    logic [30:0] mant;
  } item_t;

  typedef struct packed {
    logic [31:0] x;
    region_e     region;
  } carry_t;

  typedef struct packed {
    logic [31:0] drag;
    region_e     region;
    logic        sat;
  } res_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = v;
    res = '0;
    bt  = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // c_k = floor(sqrt(c_(k-1) * 2^30)), c_0 = 2^31; entry k-1 holds c_k
  function automatic logic [EXP_STEPS*31-1:0] root_tab_f();
    logic [63:0]              c;
    logic [EXP_STEPS*31-1:0]  tab;
    c   = 64'd1 << 31;
    tab = '0;
    for (int k = 1; k <= EXP_STEPS; k++) begin
      c = isqrt64(c << 30);
      tab[(k-1)*31 +: 31] = c[30:0];
    end
    return tab;
  endfunction

  localparam logic [EXP_STEPS*31-1:0] ROOT_TAB = root_tab_f();

endpackage

[hdl/sdre_in_if.sv]
interface sdre_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] reynolds;

  modport source (output valid, output reynolds, input ready);
  modport sink   (input valid, input reynolds, output ready);
endinterface

[hdl/sdre_out_if.sv]
interface sdre_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] drag_times_re;
  logic [2:0]  region;
  logic        saturated;

  modport source (output valid, output drag_times_re, output region, output saturated,
                  input ready);
  modport sink   (input valid, input drag_times_re, input region, input saturated,
                  output ready);
endinterface

[hdl/sphere_drag_cd_re_evaluator_core.sv]
// An accepted Reynolds beat passes the front register, the queue, 24 log2 squaring
// stages, 24 exp2 root stages and scaling before its result beat is offered.
// Throughput: one item per cycle unless the output stalls; each squaring or root
// product has a stage of its own. The front and back stall independently through a
// 4-entry queue. Reset (asynchronous, active low) empties the queue and clears all
// valid bits; no state is kept between items.
`include "sphere_drag_cd_re_evaluator_core_macros.svh"

module sphere_drag_cd_re_evaluator_core #(
  parameter int unsigned FracBits   = sdre_pkg::FRAC_BITS_DEF,
  parameter int unsigned QueueDepth = sdre_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdre_in_if.sink   in_i,
  sdre_out_if.source out_o
);

  logic            fr_vld, fr_rdy, bk_vld, bk_rdy;
  sdre_pkg::item_t fr_item, bk_item;
  sdre_pkg::res_t  res;

  sdre_front #(.FracBits(FracBits)) u_front (
    .clk_i, .rst_ni,
    .vld_i(in_i.valid), .rdy_o(in_i.ready), .reynolds_i(in_i.reynolds),
    .vld_o(fr_vld), .rdy_i(fr_rdy), .item_o(fr_item)
  );

  sdre_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .vld_i(fr_vld), .rdy_o(fr_rdy), .item_i(fr_item),
    .vld_o(bk_vld), .rdy_i(bk_rdy), .item_o(bk_item)
  );

  sdre_back #(.FracBits(FracBits)) u_back (
    .clk_i, .rst_ni,
    .vld_i(bk_vld), .rdy_o(bk_rdy), .item_i(bk_item),
    .vld_o(out_o.valid), .rdy_i(out_o.ready), .res_o(res)
  );

  assign out_o.drag_times_re = res.drag;
  assign out_o.region        = res.region;
  assign out_o.saturated     = res.sat;

  `SDRE_ASSERT_IMP(a_stokes_const, clk_i, rst_ni,
    out_o.valid && (res.region == sdre_pkg::REGION_STOKES),
    ({16'd0, out_o.drag_times_re} == (48'd24 << FracBits)), "stokes value wrong")
  `SDRE_ASSERT_IMP(a_sat_clips, clk_i, rst_ni, out_o.valid && out_o.saturated,
    out_o.drag_times_re == 32'hFFFF_FFFF, "saturated beat not clipped")
  `SDRE_ASSERT_NEVER(a_newton_nosat, clk_i, rst_ni,
    out_o.valid && (res.region == sdre_pkg::REGION_NEWTON) && out_o.saturated,
    "newton range saturated")

endmodule

[hdl/sdre_front.sv]
module sdre_front #(
  parameter int unsigned FracBits = sdre_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  output logic            rdy_o,
  input  logic [31:0]     reynolds_i,
  output logic            vld_o,
  input  logic            rdy_i,
  output sdre_pkg::item_t item_o
);

  localparam logic [63:0] ThrStokes = ((64'd1 << FracBits) + 64'd5) / 64'd10;
  localparam logic [63:0] ThrLow    = 64'd2 << FracBits;
  localparam logic [63:0] ThrMid    = 64'd20 << FracBits;
  localparam logic [63:0] ThrHigh   = 64'd260 << FracBits;

  logic            vld_q;
  sdre_pkg::item_t item_q, item_d;
  logic [63:0]     xw;

  assign xw = {32'd0, reynolds_i};

  always_comb begin
    item_d.x    = reynolds_i;
    item_d.lead = '0;
    for (int b = 0; b < 32; b++) begin
      if (reynolds_i[b]) item_d.lead = 5'(b);
    end
    if (item_d.lead <= 5'd30) begin
      item_d.mant = 31'(reynolds_i << (5'd30 - item_d.lead));
    end else begin
      item_d.mant = reynolds_i[31:1];
    end
    if (xw < ThrStokes)    item_d.region = sdre_pkg::REGION_STOKES;
    else if (xw < ThrLow)  item_d.region = sdre_pkg::REGION_LOW;
    else if (xw < ThrMid)  item_d.region = sdre_pkg::REGION_MID;
    else if (xw < ThrHigh) item_d.region = sdre_pkg::REGION_HIGH;
    else                   item_d.region = sdre_pkg::REGION_NEWTON;
  end

  assign rdy_o  = !vld_q || rdy_i;
  assign vld_o  = vld_q;
  assign item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) item_q <= item_d;
  end

endmodule

[hdl/sdre_queue.sv]
module sdre_queue #(
  parameter int unsigned Depth = sdre_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  output logic            rdy_o,
  input  sdre_pkg::item_t item_i,
  output logic            vld_o,
  input  logic            rdy_i,
  output sdre_pkg::item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  sdre_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign rdy_o  = (cnt_q != CntW'(Depth));
  assign vld_o  = (cnt_q != '0);
  assign item_o = mem_q[rd_q];
  assign push   = vld_i && rdy_o;
  assign pop    = vld_o && rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_i;
  end

endmodule

[hdl/sdre_back.sv]
module sdre_back #(
  parameter int unsigned FracBits = sdre_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  output logic            rdy_o,
  input  sdre_pkg::item_t item_i,
  output logic            vld_o,
  input  logic            rdy_i,
  output sdre_pkg::res_t  res_o
);

  localparam int unsigned NS  = sdre_pkg::EXP_STEPS;
  // stage indexes
  localparam int unsigned StE = NS + 1;      // log2 assembled
  localparam int unsigned StA = NS + 2;      // log10 term product
  localparam int unsigned StB = NS + 3;      // exponent chosen
  localparam int unsigned StC = NS + 4;      // exponent times log2
  localparam int unsigned StX = NS + 5;      // exp2 start
  localparam int unsigned StS = StX + NS + 1; // scale by integer part
  localparam int unsigned StT = StS + 1;
  localparam int unsigned StV = StT + 1;
  localparam int unsigned StO = StV + 1;
  localparam int unsigned NSt = StO + 1;

  logic                adv, pop;
  logic [NSt-1:0]      vld_q;
  sdre_pkg::carry_t    cy_q [NSt];

  // log2 section
  logic [30:0]         lm_q [NS+1];
  logic [30:0]         lm_d [NS+1];
  logic [23:0]         lf_q [NS+1];
  logic [23:0]         lf_d [NS+1];
  logic [4:0]          ln_q [NS+1];
  logic [61:0]         sq   [NS+1];

  logic signed [31:0]  lge_q, lga_q, lgb_q, ipart, lge_d;
  logic signed [49:0]  pa_q, pa_d;
  logic signed [31:0]  mc_q, mc_d, e_val;
  logic signed [63:0]  pc;
  logic signed [31:0]  y_q;

  // exp2 section
  logic [31:0]         xr_q [NS+1];
  logic [31:0]         xr_d [NS+1];
  logic [62:0]         xp   [NS+1];
  logic [23:0]         xf_q [NS+1];
  logic [7:0]          xi_q [NS+1];

  logic [35:0]         p_q, p_d, pt_q;
  logic [7:0]          ni;
  logic [5:0]          ic;
  logic [57:0]         tq_q, tq_d;
  logic [54:0]         px_q, px_d;
  logic [21:0]         kc;
  logic [47:0]         v_q, v_d;
  logic [31:0]         r4_q, r4_d;
  logic [47:0]         fin;
  sdre_pkg::res_t      res_q, res_d;

  assign adv   = !vld_q[NSt-1] || rdy_i;
  assign rdy_o = adv;
  assign pop   = vld_i && adv;
  assign vld_o = vld_q[NSt-1];
  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSt-2:0], pop};
    end
  end

  // log2 fraction: square, take a bit when the square reaches two
  always_comb begin
    lm_d[0] = item_i.mant;
    lf_d[0] = '0;
    sq[0]   = '0;
    for (int k = 1; k <= NS; k++) begin
      sq[k] = 62'(lm_q[k-1]) * 62'(lm_q[k-1]);
      if (sq[k][61]) begin
        lm_d[k] = sq[k][61:31];
        lf_d[k] = {lf_q[k-1][22:0], 1'b1};
      end else begin
        lm_d[k] = sq[k][60:30];
        lf_d[k] = {lf_q[k-1][22:0], 1'b0};
      end
    end
  end

  always_comb begin
    ipart = $signed({27'd0, ln_q[NS]}) - $signed(32'(FracBits));
    lge_d = (ipart <<< 24) + $signed({8'd0, lf_q[NS]});
    pa_d  = 50'(lge_q) * 50'(sdre_pkg::K_LOGTERM);
    e_val = sdre_pkg::K_082 - 32'(pa_q >>> 24);
    case (cy_q[StA].region)
      sdre_pkg::REGION_LOW: mc_d = e_val;
      sdre_pkg::REGION_MID: mc_d = sdre_pkg::K_06305;
      default:              mc_d = sdre_pkg::K_045;
    endcase
    pc = mc_q * lgb_q;
  end

  // exp2 of the fraction: one root factor per bit
  always_comb begin
    xr_d[0] = 32'd1 << 30;
    xp[0]   = '0;
    for (int k = 1; k <= NS; k++) begin
      xp[k] = 63'(xr_q[k-1]) * 63'(sdre_pkg::ROOT_TAB[(k-1)*31 +: 31]);
      if (xf_q[k-1][NS-k]) xr_d[k] = xp[k][61:30];
      else                 xr_d[k] = xr_q[k-1];
    end
  end

  always_comb begin
    ni = 8'(-$signed(xi_q[NS]));
    ic = ($signed(xi_q[NS]) > 8'sd32) ? 6'd32 : 6'(xi_q[NS]);
    if (!xi_q[NS][7]) begin
      p_d = 36'({32'd0, xr_q[NS]} << ic);
    end else if (ni > 8'd62) begin
      p_d = '0;
    end else begin
      p_d = 36'({32'd0, xr_q[NS]} >> ni);
    end
    kc   = (cy_q[StS].region == sdre_pkg::REGION_LOW) ? sdre_pkg::K_01315
                                                      : sdre_pkg::K_01935;
    tq_d = 58'(p_q) * 58'(kc);
    px_d = 55'(cy_q[StS].x) * 55'(sdre_pkg::K_044);
    if (cy_q[StT].region == sdre_pkg::REGION_HIGH) begin
      v_d = 48'd10 * 48'(pt_q);
    end else begin
      v_d = 48'd24 * ((48'd1 << 30) + 48'(tq_q >> 24));
    end
    r4_d = 32'((px_q + (55'd1 << 23)) >> 24);
  end

  always_comb begin
    case (cy_q[StV].region)
      sdre_pkg::REGION_STOKES: fin = 48'd24 << FracBits;
      sdre_pkg::REGION_NEWTON: fin = 48'(r4_q);
      default:                 fin = (v_q + (48'd1 << (29 - FracBits))) >> (30 - FracBits);
    endcase
    res_d.region = cy_q[StV].region;
    res_d.sat    = (fin > 48'hFFFF_FFFF);
    res_d.drag   = res_d.sat ? 32'hFFFF_FFFF : fin[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cy_q[0] <= '{x: item_i.x, region: item_i.region};
      for (int s = 1; s < NSt; s++) cy_q[s] <= cy_q[s-1];
      ln_q[0] <= item_i.lead;
      for (int k = 0; k <= NS; k++) begin
        lm_q[k] <= lm_d[k];
        lf_q[k] <= lf_d[k];
      end
      for (int k = 1; k <= NS; k++) ln_q[k] <= ln_q[k-1];
      lge_q <= lge_d;
      pa_q  <= pa_d;
      lga_q <= lge_q;
      mc_q  <= mc_d;
      lgb_q <= lga_q;
      y_q   <= 32'(pc >>> 24);
      xr_q[0] <= xr_d[0];
      xf_q[0] <= y_q[23:0];
      xi_q[0] <= y_q[31:24];
      for (int k = 1; k <= NS; k++) begin
        xr_q[k] <= xr_d[k];
        xf_q[k] <= xf_q[k-1];
        xi_q[k] <= xi_q[k-1];
      end
      p_q   <= p_d;
      tq_q  <= tq_d;
      px_q  <= px_d;
      pt_q  <= p_q;
      v_q   <= v_d;
      r4_q  <= r4_d;
      res_q <= res_d;
    end
  end

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC     = 16;
  localparam int unsigned LATENCY  = 70;
  localparam int unsigned WD_LIMIT = 5000;

  localparam longint signed Q24_ONE = 64'sd16777216;

  logic clk_i;
  logic rst_ni;

  sdre_in_if  in_ch ();
  sdre_out_if out_ch ();

  sphere_drag_cd_re_evaluator_core #(
    .FracBits(FRAC)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  sdre_pkg::res_t  drag_q[$];
  longint unsigned exp2_roots[1:24];
  int unsigned     n_fail;
  int unsigned     n_sent;
  int unsigned     n_checked;
  int unsigned     n_sat;
  int unsigned     region_hits[5];
  int unsigned     idle_cycles;
  bit              sender_bursty;
  bit              hold_req;
  int unsigned     hold_left;

  // floor(sqrt(v)), bit by bit from the top
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned cand;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  function automatic longint signed q24_mul(longint signed a, longint signed b);
    return (a * b) >>> 24;
  endfunction

  function automatic longint signed log2_of_re(longint unsigned x);
    int              lead;
    longint unsigned m;
    longint signed   fr;
    lead = 0;
    fr   = 0;
    for (int k = 31; k >= 0; k--) begin
      if (x[k]) begin
        lead = k;
        break;
      end
    end
    m = (lead <= 30) ? (x << (30 - lead)) : (x >> 1);
    for (int k = 0; k < 24; k++) begin
      m  = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd1 << 31)) begin
        fr = fr | 1;
        m  = m >> 1;
      end
    end
    return longint'(lead - int'(FRAC)) * Q24_ONE + fr;
  endfunction

  function automatic longint unsigned pow2_q30(longint signed y);
    longint signed   ip;
    longint signed   fp;
    longint unsigned r;
    ip = y >>> 24;
    fp = y - ip * Q24_ONE;
    r  = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      if (fp[24-k]) r = (r * exp2_roots[k]) >> 30;
    end
    if (ip >= 0) begin
      if (ip > 32) ip = 32;
      r = r << ip;
    end else begin
      r = (-ip > 62) ? 64'd0 : (r >> (-ip));
    end
    return r;
  endfunction

  function automatic longint unsigned q30_round(longint unsigned v);
    return (v + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
  endfunction

  function automatic sdre_pkg::res_t drag_expect(logic [31:0] re);
    longint unsigned x;
    longint unsigned v;
    longint unsigned p;
    longint signed   lg;
    longint signed   ex;
    sdre_pkg::res_t  r;
    x = re;
    r.sat = 1'b0;
    if (x < ((64'd1 << FRAC) + 5) / 10) begin
      r.region = sdre_pkg::REGION_STOKES;
      v = 64'd24 << FRAC;
    end else if (x < (64'd2 << FRAC)) begin
      r.region = sdre_pkg::REGION_LOW;
      lg = log2_of_re(x);
      ex = longint'(sdre_pkg::K_082) - q24_mul(longint'(sdre_pkg::K_LOGTERM), lg);
      p  = pow2_q30(q24_mul(ex, lg));
      v  = q30_round(64'd24 * ((64'd1 << 30) + ((p * sdre_pkg::K_01315) >> 24)));
    end else if (x < (64'd20 << FRAC)) begin
      r.region = sdre_pkg::REGION_MID;
      lg = log2_of_re(x);
      p  = pow2_q30(q24_mul(longint'(sdre_pkg::K_06305), lg));
      v  = q30_round(64'd24 * ((64'd1 << 30) + ((p * sdre_pkg::K_01935) >> 24)));
    end else if (x < (64'd260 << FRAC)) begin
      r.region = sdre_pkg::REGION_HIGH;
      lg = log2_of_re(x);
      p  = pow2_q30(q24_mul(longint'(sdre_pkg::K_045), lg));
      v  = q30_round(64'd10 * p);
    end else begin
      r.region = sdre_pkg::REGION_NEWTON;
      v = (x * sdre_pkg::K_044 + (64'd1 << 23)) >> 24;
    end
    if (v > 64'hFFFF_FFFF) begin
      v     = 64'hFFFF_FFFF;
      r.sat = 1'b1;
    end
    r.drag = v[31:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned d;
    d = $urandom_range(0, 99);
    if (sender_bursty || d < 60) return 0;
    if (d < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_re(logic [31:0] re);
    int unsigned gap;
    in_ch.valid    <= 1'b1;
    in_ch.reynolds <= re;
    do @(posedge clk_i); while (!in_ch.ready);
    drag_q.push_back(drag_expect(re));
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] re_in_region(int unsigned sel);
    case (sel)
      0:       return $urandom_range(0, 6553);
      1:       return $urandom_range(6554, (2 << FRAC) - 1);
      2:       return $urandom_range(2 << FRAC, (20 << FRAC) - 1);
      3:       return $urandom_range(20 << FRAC, (260 << FRAC) - 1);
      4:       return $urandom_range(260 << FRAC, 32'hFFFF_FFFF);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_boundaries();
    logic [31:0] edges[$];
    edges = '{32'd0, 32'd1, 32'd6553, 32'd6554, 32'd6555, 32'h0000_FFFF,
              32'h0001_0000, 32'h0001_FFFF, 32'h0002_0000, 32'h0002_0001,
              (20 << FRAC) - 1, 20 << FRAC, (260 << FRAC) - 1, 260 << FRAC,
              (260 << FRAC) + 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
              32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    sender_bursty = 1'b0;
    foreach (edges[i]) send_re(edges[i]);
  endtask

  task automatic test_region_mix(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 150 == 0) sender_bursty = ($urandom_range(0, 3) == 0);
      send_re(re_in_region($urandom_range(0, 5)));
    end
    sender_bursty = 1'b0;
  endtask

  // Stall the result side for a long stretch while beats keep arriving.
  task automatic test_backpressure();
    hold_req = 1'b1;
    sender_bursty = 1'b1;
    for (int i = 0; i < 120; i++) send_re(re_in_region($urandom_range(1, 3)));
    sender_bursty = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_req) begin
      hold_req     = 1'b0;
      hold_left    <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b1)
                      && ($urandom_range(0, 49) != 0);
    end
  end

  always @(posedge clk_i) begin
    sdre_pkg::res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (drag_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: drag=%h region=%0d sat=%b",
                 $time, out_ch.drag_times_re, out_ch.region, out_ch.saturated);
        n_fail++;
      end else begin
        want = drag_q.pop_front();
        n_checked++;
        region_hits[want.region]++;
        if (want.sat) n_sat++;
        if (out_ch.drag_times_re !== want.drag) begin
          $display("%0t: drag_times_re expected %h actual %h",
                   $time, want.drag, out_ch.drag_times_re);
          n_fail++;
        end
        if (out_ch.region !== want.region) begin
          $display("%0t: region expected %0d actual %0d", $time, want.region, out_ch.region);
          n_fail++;
        end
        if (out_ch.saturated !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, out_ch.saturated);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    longint unsigned c;
    n_fail = 0;
    n_sent = 0;
    n_checked = 0;
    n_sat = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    sender_bursty = 1'b0;
    foreach (region_hits[i]) region_hits[i] = 0;
    c = 64'd1 << 31;
    for (int k = 1; k <= 24; k++) begin
      c = floor_sqrt(c << 30);
      exp2_roots[k] = c;
    end
    in_ch.valid    = 1'b0;
    in_ch.reynolds = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_boundaries();
    test_region_mix(800);
    test_backpressure();
    test_region_mix(830);

    in_ch.valid <= 1'b0;
    while (drag_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);

    $display("Sent %0d Reynolds beats, checked %0d results, %0d saturated.",
             n_sent, n_checked, n_sat);
    $display("Results per region: stokes %0d, low %0d, mid %0d, high %0d, newton %0d.",
             region_hits[0], region_hits[1], region_hits[2], region_hits[3], region_hits[4]);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
